/* design/hsfc_pkg.sv */
package hsfc_pkg;

    localparam int SET_BITS = 7;
    localparam int WAYS     = 10;
    localparam int NUM_SETS = 1 << SET_BITS;
    localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FILL_BITS = $clog2(WAYS + 1);

    localparam logic [1:0] STATUS_HIT      = 2'd0;
    localparam logic [1:0] STATUS_MISS     = 2'd1;
    localparam logic [1:0] STATUS_DISABLED = 2'd2;

    localparam logic [31:0] HASH_INIT = 32'hdeadbeef + 32'd32;

    typedef struct packed {
        logic [31:0] pid;
        logic [63:0] inode;
        logic [31:0] device;
        logic [63:0] etime;
    } key_t;

    typedef struct packed {
        key_t        key;
        logic [31:0] hits;
    } way_t;

    typedef struct packed {
        logic [FILL_BITS-1:0] fill;
        logic [WAY_BITS-1:0]  oldest;
    } set_meta_t;

    typedef struct packed {
        logic [1:0]  lookup_status;
        logic [31:0] hit_count;
        logic        evicted;
    } result_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } abc_t;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        rotl = (v << s) | (v >> (32 - s));
    endfunction

endpackage

/* design/hsfc_if.sv */
interface hsfc_in_if;
    import hsfc_pkg::*;
    logic valid;
    logic ready;
    logic [31:0] process_group_id;
    logic [63:0] inode_number;
    logic [31:0] device_number;
    logic [63:0] event_time;
    modport source (output valid, process_group_id, inode_number, device_number,
                    event_time, input ready);
    modport sink (input valid, process_group_id, inode_number, device_number,
                  event_time, output ready);
endinterface

interface hsfc_out_if;
    logic valid;
    logic ready;
    logic [1:0]  lookup_status;
    logic [31:0] hit_count;
    logic        evicted;
    modport source (output valid, lookup_status, hit_count, evicted, input ready);
    modport sink (input valid, lookup_status, hit_count, evicted, output ready);
endinterface

/* design/hsfc_hash.sv */
// Key hash: one mixing step per cycle, 21 steps after the start cycle
module hsfc_hash
    import hsfc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  key_t                key,
    output logic                done,
    output logic [SET_BITS-1:0] set_idx
);

    // Steps 0-5 mix block 0, 7-12 mix block 1, 14-20 are the final mix
    localparam logic [4:0] STEP_BLK1_ADD  = 5'd6;
    localparam logic [4:0] STEP_FINAL_ADD = 5'd13;
    localparam logic [4:0] STEP_LAST      = 5'd20;

    logic       busy_reg, busy_next;
    logic [4:0] step_reg, step_next;
    logic       done_reg, done_next;
    abc_t       abc_reg, abc_next;
    key_t       key_reg;

    always_comb
    begin
        logic [31:0] a, b, c;
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        a = abc_reg.a;
        b = abc_reg.b;
        c = abc_reg.c;
        if (!busy_reg)
        begin
            if (start)
            begin
                a = HASH_INIT + key.pid;
                b = HASH_INIT;
                c = HASH_INIT + key.inode[31:0];
                busy_next = 1'b1;
                step_next = '0;
            end
        end
        else
        begin
            case (step_reg)
                5'd0, 5'd7:
                begin
                    a = (a - c) ^ rotl(c, 4);  c = c + b;
                end
                5'd1, 5'd8:
                begin
                    b = (b - a) ^ rotl(a, 6);  a = a + c;
                end
                5'd2, 5'd9:
                begin
                    c = (c - b) ^ rotl(b, 8);  b = b + a;
                end
                5'd3, 5'd10:
                begin
                    a = (a - c) ^ rotl(c, 16); c = c + b;
                end
                5'd4, 5'd11:
                begin
                    b = (b - a) ^ rotl(a, 19); a = a + c;
                end
                5'd5, 5'd12:
                begin
                    c = (c - b) ^ rotl(b, 4);  b = b + a;
                end
                STEP_BLK1_ADD:
                begin
                    a = a + key_reg.inode[63:32];
                    b = b + key_reg.device;
                end
                STEP_FINAL_ADD:
                begin
                    a = a + key_reg.etime[31:0];
                    b = b + key_reg.etime[63:32];
                end
                5'd14: c = (c ^ b) - rotl(b, 14);
                5'd15: a = (a ^ c) - rotl(c, 11);
                5'd16: b = (b ^ a) - rotl(a, 25);
                5'd17: c = (c ^ b) - rotl(b, 16);
                5'd18: a = (a ^ c) - rotl(c, 4);
                5'd19: b = (b ^ a) - rotl(a, 14);
                STEP_LAST: c = (c ^ b) - rotl(b, 24);
                default: busy_next = 1'b0;
            endcase
            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                step_next = step_reg + 5'd1;
        end
        abc_next = '{a: a, b: b, c: c};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        abc_reg <= abc_next;
        if (start && !busy_reg)
            key_reg <= key;
    end

    assign done    = done_reg;
    assign set_idx = abc_reg.c[SET_BITS-1:0];

endmodule

/* design/hsfc_store.sv */
// Set storage: one wide row per set for the ways, one row of set metadata
module hsfc_store
    import hsfc_pkg::*;
(
    input  logic                clk,
    input  logic                rd_en,
    input  logic [SET_BITS-1:0] rd_addr,
    output way_t [WAYS-1:0]     rd_ways,
    output set_meta_t           rd_meta,
    input  logic                wr_en,
    input  logic [SET_BITS-1:0] wr_addr,
    input  logic [WAYS-1:0]     wr_way_mask,
    input  way_t                wr_way,
    input  set_meta_t           wr_meta
);

    way_t      way_mem  [NUM_SETS][WAYS];
    set_meta_t meta_mem [NUM_SETS];

    // Way array with per-way write enable
    always_ff @(posedge clk)
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            if (wr_en && wr_way_mask[w])
                way_mem[wr_addr][w] <= wr_way;
            if (rd_en)
                rd_ways[w] <= way_mem[rd_addr][w];
        end
    end

    // Metadata array
    always_ff @(posedge clk)
    begin
        if (wr_en)
            meta_mem[wr_addr] <= wr_meta;
        if (rd_en)
            rd_meta <= meta_mem[rd_addr];
    end

endmodule

/* design/hashed_set_fifo_cache.sv */
// Hashed set-associative cache with FIFO replacement. Each key transaction is
// hashed by a unit that does one mixing step per cycle, and the low hash bits
// pick a set. An accepted key goes through the hash unit (the set read that is
// used is issued when the hash is done), a state holding the read data and a
// state of compare and write-back into the result register. The result holds
// until taken. One key is in flight at a time, so the next key is accepted only
// after the result is taken. A write to cache_enable starts a clearing pass
// over the NUM_SETS (128) rows of the set metadata memory, during which no key
// is accepted; the pass also runs after reset. While disabled, a key is
// answered the cycle after it is accepted, and the next key is accepted only
// after that result is taken.
module hashed_set_fifo_cache
    import hsfc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_we,
    input  logic     cfg_wdata,
    hsfc_in_if.sink  in_ch,
    hsfc_out_if.source out_ch
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_HASH  = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_CMP   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic                enable_reg;
    logic [SET_BITS:0]   clr_cnt_reg, clr_cnt_next;
    logic [SET_BITS-1:0] set_reg;
    key_t                key_reg;
    result_t             res_reg, res_next;
    key_t                in_key;
    logic                accept;
    logic                hash_done;
    logic [SET_BITS-1:0] hash_set;

    way_t [WAYS-1:0]     rd_ways;
    set_meta_t           rd_meta;
    logic                mem_wr;
    logic [SET_BITS-1:0] mem_wr_addr;
    logic [WAYS-1:0]     mem_mask;
    way_t                mem_way;
    set_meta_t           mem_meta;

    assign in_key = '{pid: in_ch.process_group_id, inode: in_ch.inode_number,
                      device: in_ch.device_number, etime: in_ch.event_time};
    assign in_ch.ready = (state_reg == ST_IDLE) && !cfg_we;
    assign accept      = in_ch.valid && in_ch.ready;

    hsfc_hash u_hash (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept && enable_reg),
        .key     (in_key),
        .done    (hash_done),
        .set_idx (hash_set)
    );

    hsfc_store u_store (
        .clk         (clk),
        .rd_en       (state_reg == ST_HASH),
        .rd_addr     (hash_set),
        .rd_ways     (rd_ways),
        .rd_meta     (rd_meta),
        .wr_en       (mem_wr),
        .wr_addr     (mem_wr_addr),
        .wr_way_mask (mem_mask),
        .wr_way      (mem_way),
        .wr_meta     (mem_meta)
    );

    // Compare over the ways of the set
    logic [WAYS-1:0]     match;
    logic                hit;
    logic [WAY_BITS-1:0] hit_way;
    logic [FILL_BITS-1:0] fill_sat;
    logic [WAY_BITS-1:0] old_sat;
    logic [31:0]         hit_old;

    always_comb
    begin
        fill_sat = (rd_meta.fill > FILL_BITS'(WAYS)) ? FILL_BITS'(WAYS) : rd_meta.fill;
        old_sat  = (32'(rd_meta.oldest) >= WAYS) ? '0 : rd_meta.oldest;
        hit      = 1'b0;
        hit_way  = '0;
        hit_old  = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            match[w] = (32'(w) < 32'(fill_sat)) && (rd_ways[w].key == key_reg);
        end
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hit     = 1'b1;
                hit_way = WAY_BITS'(w);
                hit_old = rd_ways[w].hits;
            end
        end
    end

    // Sequencer, write-back and result
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        res_next     = res_reg;
        mem_wr       = 1'b0;
        mem_wr_addr  = set_reg;
        mem_mask     = '0;
        mem_way      = '{key: key_reg, hits: '0};
        mem_meta     = rd_meta;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_wr      = 1'b1;
                mem_wr_addr = clr_cnt_reg[SET_BITS-1:0];
                mem_meta    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == (SET_BITS+1)'(NUM_SETS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (enable_reg)
                        state_next = ST_HASH;
                    else
                    begin
                        res_next   = '{lookup_status: STATUS_DISABLED,
                                       hit_count: '0, evicted: 1'b0};
                        state_next = ST_OUT;
                    end
                end
            end
            ST_HASH:
            begin
                if (hash_done)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                mem_wr = 1'b1;
                if (hit)
                begin
                    mem_mask = WAYS'(1) << hit_way;
                    mem_way.hits = (hit_old == '1) ? hit_old : hit_old + 32'd1;
                    res_next = '{lookup_status: STATUS_HIT,
                                 hit_count: mem_way.hits, evicted: 1'b0};
                end
                else if (fill_sat < FILL_BITS'(WAYS))
                begin
                    mem_mask      = WAYS'(1) << fill_sat;
                    mem_meta.fill = fill_sat + 1'b1;
                    res_next = '{lookup_status: STATUS_MISS,
                                 hit_count: '0, evicted: 1'b0};
                end
                else
                begin
                    mem_mask        = WAYS'(1) << old_sat;
                    mem_meta.oldest = (32'(old_sat) == WAYS - 1) ? '0 : old_sat + 1'b1;
                    res_next = '{lookup_status: STATUS_MISS,
                                 hit_count: '0, evicted: 1'b1};
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ch.ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
        if (cfg_we)
        begin
            state_next   = ST_CLEAR;
            clr_cnt_next = '0;
        end
    end

    // Hash read happens during ST_HASH; capture the set the cycle it is ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            enable_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (cfg_we)
                enable_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (accept)
            key_reg <= in_key;
        if (state_reg == ST_HASH)
            set_reg <= hash_set;
    end

    assign out_ch.valid         = (state_reg == ST_OUT);
    assign out_ch.lookup_status = res_reg.lookup_status;
    assign out_ch.hit_count     = res_reg.hit_count;
    assign out_ch.evicted       = res_reg.evicted;

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
    import hsfc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int FILL_KEYS      = 12;

    // Directed table operations
    localparam logic [1:0] OP_SEND  = 2'd0;
    localparam logic [1:0] OP_CFG   = 2'd1;
    localparam logic [1:0] OP_DRAIN = 2'd2;
    localparam logic [1:0] OP_FILL  = 2'd3;

    // Key selector that asks for a fresh random key
    localparam logic [2:0] KEY_RANDOM = 3'd7;

    typedef struct packed {
        logic [1:0]  op;
        logic        cfg_value;
        logic [2:0]  key_sel;
        logic        has_expect;
        result_t     exp_r;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    hsfc_in_if  in_ch();
    hsfc_out_if out_ch();

    hashed_set_fifo_cache i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    // Shadow copy of the cache
    logic             model_enable;
    int               model_fill   [NUM_SETS];
    int               model_oldest [NUM_SETS];
    key_t             model_key    [NUM_SETS*WAYS];
    logic [31:0]      model_hits   [NUM_SETS*WAYS];

    result_t lookup_expect_q[$];
    int      error_count;
    int      idle_cycles;
    bit      long_hold;

    // Recently used keys, so random traffic produces hits
    key_t    key_pool[$];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [31:0] rl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic logic [31:0] key_hash(input key_t k);
        logic [31:0] w [8];
        logic [31:0] a, b, c;
        w[0] = k.pid;         w[1] = 32'd0;
        w[2] = k.inode[31:0]; w[3] = k.inode[63:32];
        w[4] = k.device;      w[5] = 32'd0;
        w[6] = k.etime[31:0]; w[7] = k.etime[63:32];
        a = 32'hdeadbeef + 32'd32; b = a; c = a;
        for (int blk = 0; blk < 2; blk++)
        begin
            a += w[blk*3]; b += w[blk*3+1]; c += w[blk*3+2];
            a -= c; a ^= rl(c, 4);  c += b;
            b -= a; b ^= rl(a, 6);  a += c;
            c -= b; c ^= rl(b, 8);  b += a;
            a -= c; a ^= rl(c, 16); c += b;
            b -= a; b ^= rl(a, 19); a += c;
            c -= b; c ^= rl(b, 4);  b += a;
        end
        a += w[6]; b += w[7];
        c ^= b; c -= rl(b, 14);
        a ^= c; a -= rl(c, 11);
        b ^= a; b -= rl(a, 25);
        c ^= b; c -= rl(b, 16);
        a ^= c; a -= rl(c, 4);
        b ^= a; b -= rl(a, 14);
        c ^= b; c -= rl(b, 24);
        return c;
    endfunction

    function automatic void write_enable_model(input logic en);
        model_enable = en;
        for (int s = 0; s < NUM_SETS; s++)
        begin
            model_fill[s]   = 0;
            model_oldest[s] = 0;
        end
    endfunction

    // Predict one lookup and update the shadow cache
    function automatic result_t predict_lookup(input key_t k);
        result_t r;
        int set_idx, base, slot;
        r = '{lookup_status: STATUS_DISABLED, hit_count: 32'd0, evicted: 1'b0};
        if (!model_enable)
            return r;
        set_idx = key_hash(k) & (NUM_SETS - 1);
        base = set_idx * WAYS;
        for (int w = 0; w < model_fill[set_idx]; w++)
        begin
            if (model_key[base+w] == k)
            begin
                if (model_hits[base+w] != 32'hffffffff)
                    model_hits[base+w] += 1;
                r.lookup_status = STATUS_HIT;
                r.hit_count = model_hits[base+w];
                return r;
            end
        end
        if (model_fill[set_idx] < WAYS)
        begin
            slot = base + model_fill[set_idx];
            model_fill[set_idx]++;
        end
        else
        begin
            slot = base + model_oldest[set_idx];
            model_oldest[set_idx] = (model_oldest[set_idx] + 1) % WAYS;
            r.evicted = 1'b1;
        end
        model_key[slot]  = k;
        model_hits[slot] = 32'd0;
        r.lookup_status = STATUS_MISS;
        return r;
    endfunction

    function automatic key_t random_key();
        key_t k;
        k.pid    = $urandom;
        k.inode  = {$urandom, $urandom};
        k.device = $urandom;
        k.etime  = {$urandom, $urandom};
        return k;
    endfunction

    // Send one key; stays valid across back-to-back sends
    task automatic send_key(input key_t k, input bit chk, input result_t given);
        result_t r;
        in_ch.valid            <= 1'b1;
        in_ch.process_group_id <= k.pid;
        in_ch.inode_number     <= k.inode;
        in_ch.device_number    <= k.device;
        in_ch.event_time       <= k.etime;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        r = predict_lookup(k);
        if (chk && r != given)
        begin
            $error("directed row disagrees with predictor: exp %h got %h", given, r);
            error_count++;
        end
        lookup_expect_q.push_back(r);
        key_pool.push_back(k);
        if (key_pool.size() > 64)
            void'(key_pool.pop_front());
    endtask

    // Send n random keys that all land in the set of the anchor key
    task automatic fill_set(input key_t anchor, input int n);
        key_t k;
        logic [31:0] target;
        int sent;
        target = key_hash(anchor) & (NUM_SETS - 1);
        sent = 0;
        while (sent < n)
        begin
            k = random_key();
            if ((key_hash(k) & (NUM_SETS - 1)) == target)
            begin
                send_key(k, 1'b0, '0);
                sent++;
            end
        end
    endtask

    task automatic idle_in(input int n);
        in_ch.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (lookup_expect_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_enable(input logic en);
        cfg_we    <= 1'b1;
        cfg_wdata <= en;
        @(posedge clk);
        cfg_we    <= 1'b0;
        write_enable_model(en);
    endtask

    task automatic random_phase(input int n);
        key_t k;
        int burst;
        while (n > 0)
        begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && n > 0)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: k = key_pool.size() ? key_pool[$urandom_range(0,
                                 key_pool.size()-1)] : random_key();
                    3: k = '{pid: '1, inode: '1, device: '1, etime: '1};
                    default: k = random_key();
                endcase
                send_key(k, 1'b0, '0);
                burst--; n--;
            end
            if ($urandom_range(0, 2) != 0)
                idle_in($urandom_range(1, 12));
        end
    endtask

    // Receiver stall pattern, with one long hold-off
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
                long_hold = 1'b0;
            end
            case ($urandom_range(0, 7))
                0, 1:    out_ch.ready <= 1'b0;
                default: out_ch.ready <= 1'b1;
            endcase
        end
    end

    // Result checker and watchdog
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG_LIMIT)
            begin
                $display("tb_top: done, errors");
                $finish;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (lookup_expect_q.size() == 0)
                begin
                    $error("result with nothing expected");
                    error_count++;
                end
                else
                begin
                    exp_r = lookup_expect_q.pop_front();
                    if (out_ch.lookup_status !== exp_r.lookup_status)
                    begin
                        $error("lookup_status exp %0d got %0d",
                               exp_r.lookup_status, out_ch.lookup_status);
                        error_count++;
                    end
                    if (out_ch.hit_count !== exp_r.hit_count)
                    begin
                        $error("hit_count exp %0d got %0d",
                               exp_r.hit_count, out_ch.hit_count);
                        error_count++;
                    end
                    if (out_ch.evicted !== exp_r.evicted)
                    begin
                        $error("evicted exp %0d got %0d", exp_r.evicted, out_ch.evicted);
                        error_count++;
                    end
                end
            end
        end
    end

    // Directed table
    localparam result_t R_NONE = '0;
    localparam result_t R_DIS  = '{lookup_status: STATUS_DISABLED, hit_count: 0, evicted: 0};
    localparam result_t R_MISS = '{lookup_status: STATUS_MISS, hit_count: 0, evicted: 0};
    localparam result_t R_HIT1 = '{lookup_status: STATUS_HIT, hit_count: 1, evicted: 0};
    localparam result_t R_HIT2 = '{lookup_status: STATUS_HIT, hit_count: 2, evicted: 0};

    localparam int DIR_ROWS = 34;
    localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
        // Disabled after reset: everything passes through
        '{OP_SEND,  1'b0, 3'd0, 1'b1, R_DIS},
        '{OP_SEND,  1'b0, 3'd1, 1'b1, R_DIS},
        '{OP_DRAIN, 1'b0, 3'd0, 1'b0, R_NONE},
        // Enabled: misses, then hits on the same keys
        '{OP_CFG,   1'b1, 3'd0, 1'b0, R_NONE},
        '{OP_SEND,  1'b0, 3'd0, 1'b1, R_MISS},
        '{OP_SEND,  1'b0, 3'd1, 1'b1, R_MISS},
        '{OP_SEND,  1'b0, 3'd2, 1'b1, R_MISS},
        '{OP_SEND,  1'b0, 3'd3, 1'b1, R_MISS},
        '{OP_SEND,  1'b0, 3'd4, 1'b1, R_MISS},
        '{OP_SEND,  1'b0, 3'd5, 1'b1, R_MISS},
        '{OP_SEND,  1'b0, 3'd0, 1'b1, R_HIT1},
        '{OP_SEND,  1'b0, 3'd1, 1'b1, R_HIT1},
        '{OP_SEND,  1'b0, 3'd2, 1'b1, R_HIT1},
        '{OP_SEND,  1'b0, 3'd3, 1'b1, R_HIT1},
        '{OP_SEND,  1'b0, 3'd4, 1'b1, R_HIT1},
        '{OP_SEND,  1'b0, 3'd5, 1'b1, R_HIT1},
        '{OP_SEND,  1'b0, 3'd1, 1'b1, R_HIT2},
        '{OP_SEND,  1'b0, 3'd0, 1'b1, R_HIT2},
        '{OP_DRAIN, 1'b0, 3'd0, 1'b0, R_NONE},
        // Re-writing enable clears: the same key misses again
        '{OP_CFG,   1'b1, 3'd0, 1'b0, R_NONE},
        '{OP_SEND,  1'b0, 3'd0, 1'b1, R_MISS},
        // Overfill that set so the oldest entries get evicted
        '{OP_FILL,  1'b0, 3'd0, 1'b0, R_NONE},
        '{OP_SEND,  1'b0, 3'd0, 1'b0, R_NONE},
        '{OP_SEND,  1'b0, KEY_RANDOM, 1'b0, R_NONE},
        '{OP_SEND,  1'b0, KEY_RANDOM, 1'b0, R_NONE},
        '{OP_SEND,  1'b0, KEY_RANDOM, 1'b0, R_NONE},
        '{OP_SEND,  1'b0, KEY_RANDOM, 1'b0, R_NONE},
        '{OP_SEND,  1'b0, KEY_RANDOM, 1'b0, R_NONE},
        '{OP_SEND,  1'b0, KEY_RANDOM, 1'b0, R_NONE},
        '{OP_DRAIN, 1'b0, 3'd0, 1'b0, R_NONE},
        // Disable clears and passes through
        '{OP_CFG,   1'b0, 3'd0, 1'b0, R_NONE},
        '{OP_SEND,  1'b0, 3'd0, 1'b1, R_DIS},
        '{OP_SEND,  1'b0, 3'd4, 1'b1, R_DIS},
        '{OP_DRAIN, 1'b0, 3'd0, 1'b0, R_NONE}
    };

    key_t dir_key [6];

    initial
    begin
        key_t k;
        stim_row_t row;
        error_count = 0;
        idle_cycles = 0;
        long_hold   = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.process_group_id = '0;
        in_ch.inode_number     = '0;
        in_ch.device_number    = '0;
        in_ch.event_time       = '0;
        write_enable_model(1'b0);
        dir_key[0] = '0;
        dir_key[1] = '{pid: '1, inode: '1, device: '1, etime: '1};
        dir_key[2] = '{pid: 32'h1, inode: 64'h8000_0000_0000_0000, device: 32'h0,
                       etime: 64'h1};
        dir_key[3] = '{pid: 32'h8000_0000, inode: 64'h1, device: '1, etime: '0};
        dir_key[4] = random_key();
        dir_key[5] = random_key();
        repeat (2) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = DIR_TABLE[i];
            case (row.op)
                OP_SEND:
                begin
                    if (row.key_sel == KEY_RANDOM)
                        k = random_key();
                    else
                        k = dir_key[row.key_sel];
                    send_key(k, row.has_expect, row.exp_r);
                end
                OP_CFG:   write_enable(row.cfg_value);
                OP_DRAIN: wait_drained();
                OP_FILL:  fill_set(dir_key[row.key_sel], FILL_KEYS);
                default:  ;
            endcase
        end

        // Random phases across settings, with one long receiver hold-off
        write_enable(1'b1);
        long_hold = 1'b1;
        random_phase(200);
        wait_drained();
        write_enable(1'b0);
        random_phase(40);
        wait_drained();
        write_enable(1'b1);
        random_phase(270);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && lookup_expect_q.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
design/hsfc_pkg.sv
design/hsfc_if.sv
design/hsfc_hash.sv
design/hsfc_store.sv
design/hashed_set_fifo_cache.sv
tb/sv/tb_top.sv
